FILE: src/dsa_pkg.sv
// Shared types and codes of the descriptor slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dsa_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_UPDATE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_OOM     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] slot_index;
		logic [31:0] texture_handle;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  granted_slot;
		logic        is_allocated;
		logic        write_valid;
		logic [9:0]  write_slot;
		logic [31:0] write_texture;
	} rsp_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: src/dsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the used marks and the free stack; no dependencies.
`default_nettype none

module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/dsa_ctrl.sv
// Controller of the descriptor slot allocator: clearing pass, accept, execute.
// Uses types from dsa_pkg; drives dsa_dp through command and status structs.
`default_nettype none

module dsa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire dsa_pkg::dp_sts_t sts,
	output dsa_pkg::dp_cmd_t      cmd
);

	dsa_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.accept     = 1'b0;
		cmd.exec       = 1'b0;
		case (state_q)
			dsa_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = dsa_pkg::S_IDLE;
				end
			end
			dsa_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = dsa_pkg::S_EXEC;
				end
			end
			dsa_pkg::S_EXEC: begin
				// hold until the result register can take the answer
				cmd.exec = sts.out_free;
				if (sts.out_free) begin
					state_d = dsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dsa_pkg::S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/dsa_dp.sv
// Datapath of the descriptor slot allocator: request and result registers,
// counters, heap enable, used-mark and free-stack RAMs (dsa_ram); uses dsa_pkg.
`default_nettype none

module dsa_dp #(
	parameter int TABLE_SLOTS = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dsa_pkg::dp_cmd_t cmd,
	output dsa_pkg::dp_sts_t      sts,
	input  wire dsa_pkg::req_t    req_data,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output dsa_pkg::rsp_t         rsp_data
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	dsa_pkg::req_t req_q;
	dsa_pkg::rsp_t rsp_q, rsp_d;
	logic          rsp_valid_q;
	logic          heap_q;
	logic [CW-1:0] free_cnt_q, free_cnt_d;
	logic [CW-1:0] fresh_q, fresh_d;
	logic [SW-1:0] clr_addr_q;

	logic          used_we, used_wdata, used_rdata;
	logic [SW-1:0] used_waddr;
	logic          stk_we;
	logic [SW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

	logic          in_range, tex_ok;
	logic [SW-1:0] idx;
	logic [SW-1:0] slot;

	dsa_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (cmd.accept),
		.raddr (req_data.slot_index[SW-1:0]),
		.rdata (used_rdata)
	);

	assign stk_raddr = SW'(free_cnt_q - CW'(1));

	dsa_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (cmd.accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign idx      = req_q.slot_index[SW-1:0];
	assign in_range = ({1'b0, req_q.slot_index} < 17'(TABLE_SLOTS));
	assign tex_ok   = heap_q && (req_q.texture_handle != 32'd0);

	assign sts.clear_last = (clr_addr_q == SW'(TABLE_SLOTS - 1));
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	always_comb begin
		rsp_d      = '0;
		free_cnt_d = free_cnt_q;
		fresh_d    = fresh_q;
		used_we    = 1'b0;
		used_waddr = clr_addr_q;
		used_wdata = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = free_cnt_q[SW-1:0];
		stk_wdata  = idx;
		slot       = stk_rdata;
		case (req_q.opcode)
			dsa_pkg::OP_ALLOC: begin
				if (!tex_ok) begin
					rsp_d.status = dsa_pkg::ST_INVALID;
				end else if (free_cnt_q != '0) begin
					free_cnt_d = free_cnt_q - CW'(1);
				end else if (fresh_q < CW'(TABLE_SLOTS)) begin
					slot    = fresh_q[SW-1:0];
					fresh_d = fresh_q + CW'(1);
				end else begin
					rsp_d.status = dsa_pkg::ST_OOM;
				end
				if (tex_ok && rsp_d.status == dsa_pkg::ST_OK) begin
					used_we             = cmd.exec;
					used_waddr          = slot;
					used_wdata          = 1'b1;
					rsp_d.granted_slot  = 10'(slot);
					rsp_d.write_valid   = 1'b1;
					rsp_d.write_slot    = 10'(slot);
					rsp_d.write_texture = req_q.texture_handle;
				end
			end
			dsa_pkg::OP_FREE: begin
				if (in_range && used_rdata && free_cnt_q < CW'(TABLE_SLOTS)) begin
					used_we    = cmd.exec;
					used_waddr = idx;
					stk_we     = cmd.exec;
					free_cnt_d = free_cnt_q + CW'(1);
				end
			end
			dsa_pkg::OP_UPDATE: begin
				if (!tex_ok || !in_range) begin
					rsp_d.status = dsa_pkg::ST_INVALID;
				end else begin
					rsp_d.write_valid   = 1'b1;
					rsp_d.write_slot    = 10'(idx);
					rsp_d.write_texture = req_q.texture_handle;
				end
			end
			dsa_pkg::OP_QUERY: begin
				rsp_d.is_allocated = in_range && used_rdata;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
		if (cmd.clear_step) begin
			used_we    = 1'b1;
			used_waddr = clr_addr_q;
			used_wdata = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q      <= 1'b1;
			free_cnt_q  <= '0;
			fresh_q     <= '0;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				heap_q <= cfg_data;
			end
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + SW'(1);
			end
			if (cmd.exec) begin
				free_cnt_q  <= free_cnt_d;
				fresh_q     <= fresh_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_data;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

FILE: src/descriptor_slot_allocator_unit.sv
// Top level of the descriptor slot allocator: controller plus datapath.
// Depends on dsa_pkg, dsa_ctrl, dsa_dp and dsa_ram.
//
// Each request is handled in two steps: the accepting edge reads the used-mark
// RAM and the top of the free-stack RAM, and a later edge, once the result
// register is free, does the read-modify-write of both RAMs and loads the
// result register. A new request is taken while a finished result still
// waits in the result register. After reset a clearing pass writes every used
// mark to zero, one slot a cycle, so no request is taken until all TABLE_SLOTS
// marks (1024 by default) are cleared. The heap enable register is written at
// any time; it resets to one.
`default_nettype none

module descriptor_slot_allocator_unit #(
	parameter int TABLE_SLOTS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire dsa_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output dsa_pkg::rsp_t      rsp_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_data
);

	dsa_pkg::dp_cmd_t cmd;
	dsa_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	dsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dsa_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

FILE: bench/descriptor_slot_allocator_unit_tb.sv
// Self-checking bench for descriptor_slot_allocator_unit: directed and random requests,
// heap enable writes between phases, and responses checked against an in-bench slot model.
// Depends on dsa_pkg and the allocator RTL only.

module descriptor_slot_allocator_unit_tb;

	localparam int SLOTS = 1024;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		W_REQ,
		W_CFG,
		W_DRAIN
	} work_kind_t;

	typedef struct packed {
		work_kind_t    kind;
		dsa_pkg::req_t req;
		logic          heap;
	} work_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	dsa_pkg::req_t req_data = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	dsa_pkg::rsp_t rsp_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_data = 1'b0;

	work_t         pending_work[$];
	dsa_pkg::rsp_t awaited_responses[$];

	bit          heap_on = 1'b1;
	bit          slot_used[SLOTS];
	logic [31:0] slot_handle[SLOTS];
	logic [9:0]  freed_slots[SLOTS];
	int          freed_depth = 0;
	int          fresh_next = 0;

	bit            req_busy = 1'b0;
	bit            cfg_busy = 1'b0;
	int            req_gap = 0;
	int            req_calm = 0;
	int            rsp_calm = 0;
	int            rsp_stall = 0;
	int            rsp_seen = 0;
	int            fail_count = 0;
	int            op_count[4];
	int            oom_count = 0;
	int            invalid_count = 0;
	int            cfg_writes = 0;
	dsa_pkg::rsp_t predicted;
	dsa_pkg::rsp_t expected_rsp;

	descriptor_slot_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic dsa_pkg::rsp_t allocator_response(dsa_pkg::req_t r);
		dsa_pkg::rsp_t o;
		logic [9:0]    slot;
		bit            got;
		bit            in_range;
		o = '0;
		o.status = dsa_pkg::ST_OK;
		in_range = r.slot_index < SLOTS;
		slot = r.slot_index[9:0];
		case (r.opcode)
			dsa_pkg::OP_ALLOC: begin
				if (!heap_on || r.texture_handle == 0) begin
					o.status = dsa_pkg::ST_INVALID;
				end else begin
					got = 1'b1;
					if (freed_depth > 0) begin
						freed_depth--;
						slot = freed_slots[freed_depth];
					end else if (fresh_next < SLOTS) begin
						slot = fresh_next[9:0];
						fresh_next++;
					end else begin
						got = 1'b0;
					end
					if (!got) begin
						o.status = dsa_pkg::ST_OOM;
					end else begin
						slot_used[slot] = 1'b1;
						slot_handle[slot] = r.texture_handle;
						o.granted_slot = slot;
						o.write_valid = 1'b1;
						o.write_slot = slot;
						o.write_texture = r.texture_handle;
					end
				end
			end
			dsa_pkg::OP_FREE: begin
				if (in_range && slot_used[slot] && freed_depth < SLOTS) begin
					slot_used[slot] = 1'b0;
					slot_handle[slot] = '0;
					freed_slots[freed_depth] = slot;
					freed_depth++;
				end
			end
			dsa_pkg::OP_UPDATE: begin
				if (!heap_on || !in_range || r.texture_handle == 0) begin
					o.status = dsa_pkg::ST_INVALID;
				end else begin
					slot_handle[slot] = r.texture_handle;
					o.write_valid = 1'b1;
					o.write_slot = slot;
					o.write_texture = r.texture_handle;
				end
			end
			default: begin
				o.is_allocated = in_range && slot_used[slot];
			end
		endcase
		return o;
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(15, 40);
		return $urandom_range(0, 6);
	endfunction

	function automatic void push_req(dsa_pkg::op_t op, logic [15:0] idx, logic [31:0] tex);
		work_t w;
		w.kind = W_REQ;
		w.req.opcode = op;
		w.req.slot_index = idx;
		w.req.texture_handle = tex;
		w.heap = 1'b0;
		pending_work.insert(pending_work.size(), w);
	endfunction

	function automatic void push_ctl(work_kind_t kind, logic heap);
		work_t w;
		w = '0;
		w.kind = kind;
		w.heap = heap;
		pending_work.insert(pending_work.size(), w);
	endfunction

	function automatic logic [15:0] pick_slot(bit wide);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'($urandom_range(SLOTS, 65535));
		if (wide || r < 25)
			return 16'($urandom_range(0, SLOTS - 1));
		return 16'($urandom_range(0, 40));
	endfunction

	function automatic logic [31:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'h0;
		if (r < 12)
			return 32'hFFFF_FFFF;
		if (r < 16)
			return 32'h1 << $urandom_range(0, 31);
		return $urandom;
	endfunction

	function automatic void push_random(int count, int alloc_pct, int free_pct, int upd_pct,
			bit wide);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct)
				push_req(dsa_pkg::OP_ALLOC, 16'($urandom), pick_handle());
			else if (r < alloc_pct + free_pct)
				push_req(dsa_pkg::OP_FREE, pick_slot(wide), $urandom);
			else if (r < alloc_pct + free_pct + upd_pct)
				push_req(dsa_pkg::OP_UPDATE, pick_slot(wide), pick_handle());
			else
				push_req(dsa_pkg::OP_QUERY, pick_slot(wide), $urandom);
		end
	endfunction

	// driver: one request or heap enable write in flight at a time
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			cfg_valid <= 1'b0;
			req_busy = 1'b0;
			cfg_busy = 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				predicted = allocator_response(req_data);
				awaited_responses.insert(awaited_responses.size(), predicted);
				op_count[req_data.opcode]++;
				if (predicted.status == dsa_pkg::ST_OOM)
					oom_count++;
				if (predicted.status == dsa_pkg::ST_INVALID)
					invalid_count++;
				req_busy = 1'b0;
				req_gap = draw_wait(req_calm);
			end
			if (cfg_valid && cfg_ready) begin
				heap_on = cfg_data;
				cfg_busy = 1'b0;
			end
			if (!req_busy && !cfg_busy && pending_work.size() > 0) begin
				if (pending_work[0].kind == W_REQ) begin
					if (req_gap > 0) begin
						req_gap--;
					end else begin
						req_data <= pending_work[0].req;
						req_busy = 1'b1;
						void'(pending_work.pop_front());
					end
				end else if (awaited_responses.size() == 0) begin
					if (pending_work[0].kind == W_CFG) begin
						cfg_data <= pending_work[0].heap;
						cfg_busy = 1'b1;
						cfg_writes++;
					end
					void'(pending_work.pop_front());
				end
			end
			req_valid <= req_busy;
			cfg_valid <= cfg_busy;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// monitor: compare each response with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_responses.size() == 0) begin
					$display("%0t: unexpected response, expected none, got %p", $time, rsp_data);
					fail_count++;
				end else begin
					expected_rsp = awaited_responses.pop_front();
					check_field("status", 32'(expected_rsp.status), 32'(rsp_data.status));
					check_field("granted_slot", 32'(expected_rsp.granted_slot),
						32'(rsp_data.granted_slot));
					check_field("is_allocated", 32'(expected_rsp.is_allocated),
						32'(rsp_data.is_allocated));
					check_field("write_valid", 32'(expected_rsp.write_valid),
						32'(rsp_data.write_valid));
					check_field("write_slot", 32'(expected_rsp.write_slot),
						32'(rsp_data.write_slot));
					check_field("write_texture", expected_rsp.write_texture,
						rsp_data.write_texture);
				end
				rsp_seen++;
				rsp_stall = draw_wait(rsp_calm);
				if (rsp_seen == HOLD_AT)
					rsp_stall = HOLD_CYCLES;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
			end
			rsp_ready <= (rsp_stall == 0);
		end
	end

	initial begin
		int allocs;
		push_ctl(W_CFG, 1'b1);
		push_req(dsa_pkg::OP_QUERY, 16'd0, 32'h0);
		push_req(dsa_pkg::OP_FREE, 16'd5, 32'h0);
		push_req(dsa_pkg::OP_FREE, 16'hFFFF, 32'hFFFF_FFFF);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h0);
		push_req(dsa_pkg::OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h0000_0001);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h8000_0000);
		push_req(dsa_pkg::OP_UPDATE, 16'd1023, 32'h5A5A_5A5A);
		push_req(dsa_pkg::OP_QUERY, 16'd1023, 32'h0);
		push_req(dsa_pkg::OP_UPDATE, 16'd1024, 32'h1234_5678);
		push_req(dsa_pkg::OP_UPDATE, 16'hFFFF, 32'h0000_0001);
		push_req(dsa_pkg::OP_UPDATE, 16'd0, 32'h0);
		push_req(dsa_pkg::OP_UPDATE, 16'd2, 32'hFFFF_FFFF);
		push_req(dsa_pkg::OP_QUERY, 16'd1, 32'h0);
		push_req(dsa_pkg::OP_QUERY, 16'hFFFF, 32'h0);
		push_req(dsa_pkg::OP_FREE, 16'd1, 32'h0);
		push_req(dsa_pkg::OP_FREE, 16'd1, 32'h0);
		push_req(dsa_pkg::OP_FREE, 16'd0, 32'h0);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h0000_1234);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h0000_4321);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'hA5A5_0000);
		push_ctl(W_CFG, 1'b0);
		push_req(dsa_pkg::OP_ALLOC, 16'h0, 32'h0000_AAAA);
		push_req(dsa_pkg::OP_UPDATE, 16'd0, 32'h0000_BBBB);
		push_req(dsa_pkg::OP_FREE, 16'd2, 32'h0);
		push_req(dsa_pkg::OP_QUERY, 16'd3, 32'h0);
		push_ctl(W_CFG, 1'b1);

		push_random(100, 35, 30, 20, 1'b0);
		push_ctl(W_DRAIN, 1'b0);
		push_random(100, 35, 30, 20, 1'b0);
		push_ctl(W_CFG, 1'b0);
		push_random(40, 35, 20, 30, 1'b0);
		push_ctl(W_CFG, 1'b1);

		// fill a large part of the table with a long run of allocates
		allocs = 0;
		while (allocs < 520) begin
			if ($urandom_range(0, 9) == 0) begin
				push_random(1, 0, 0, 50, 1'b1);
			end else begin
				push_req(dsa_pkg::OP_ALLOC, 16'($urandom), 32'($urandom) | 32'h1);
				allocs++;
			end
		end
		push_random(60, 40, 40, 10, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_work.size() > 0 || req_busy || cfg_busy || awaited_responses.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Run covered %0d allocates, %0d frees, %0d updates, %0d queries.",
			op_count[dsa_pkg::OP_ALLOC], op_count[dsa_pkg::OP_FREE],
			op_count[dsa_pkg::OP_UPDATE], op_count[dsa_pkg::OP_QUERY]);
		$display("Out-of-memory answers %0d, invalid answers %0d, heap enable writes %0d.",
			oom_count, invalid_count, cfg_writes);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Timeout with %0d responses outstanding", awaited_responses.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
